// File: hdl/mono_mix_boxcar_decimator_unit_defines.svh
// Assertion macros used by the decimator top level.
`ifndef MONO_MIX_BOXCAR_DECIMATOR_UNIT_DEFINES_SVH
`define MONO_MIX_BOXCAR_DECIMATOR_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define MMBD_ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: check failed");

// Next-cycle implication, sampled on clk, off while rst is high.
`define MMBD_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

// File: hdl/mmbd_pkg.sv
// Shared types and constants of the mono-mix boxcar decimator.
`default_nettype none
package mmbd_pkg;

  localparam int SAMPLE_W  = 24;
  localparam int RAW_W     = 64;
  localparam int CFG_W     = 4;
  localparam int CFG_IDX_W = 2;

  localparam logic signed [SAMPLE_W-1:0] Q_MAX = 24'sh7FFFFF;
  localparam logic signed [SAMPLE_W-1:0] Q_MIN = 24'sh800000;

  typedef enum logic [2:0] {
    FMT_PCM16   = 3'd0,
    FMT_PCM24   = 3'd1,
    FMT_PCM32   = 3'd2,
    FMT_FLOAT32 = 3'd3,
    FMT_FLOAT64 = 3'd4
  } fmt_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SAMPLE_FORMAT     = 2'd0,
    REG_CHANNEL_COUNT     = 2'd1,
    REG_DECIMATION_FACTOR = 2'd2
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACCUM,
    ST_CHDIV,
    ST_WINDIV,
    ST_PUSH
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage
`default_nettype wire

// File: hdl/mmbd_decode.sv
// Sample decoder: PCM and float formats to Q1.23 with clip flag.
`default_nettype none
module mmbd_decode
  import mmbd_pkg::*;
(
  input  logic [2:0]                 fmt,
  input  logic [RAW_W-1:0]           raw,
  input  logic                       silent,
  output logic signed [SAMPLE_W-1:0] q,
  output logic                       clip
);

  localparam logic [25:0] MAG_SAT     = 26'h2000000;
  localparam logic [25:0] MAG_POS_LIM = 26'd8388607;
  localparam logic [25:0] MAG_NEG_LIM = 26'd8388608;

  logic [7:0]  e32;
  logic [22:0] f32;
  logic [10:0] e64;
  logic [51:0] f64;
  logic [25:0] mag32;
  logic [25:0] mag64;
  logic [25:0] mag;
  logic        neg;
  logic        is_float;

  assign e32 = raw[30:23];
  assign f32 = raw[22:0];
  assign e64 = raw[62:52];
  assign f64 = raw[51:0];

  // Scale by 2^23: left shift only for exponents 127 and 128, else right.
  always_comb begin
    if (e32 >= 8'd129) begin
      mag32 = MAG_SAT;
    end else if (e32 >= 8'd127) begin
      mag32 = {2'b00, 1'b1, f32} << (e32 - 8'd127);
    end else begin
      mag32 = 26'({2'b00, 1'b1, f32} >> (8'd127 - e32));
    end
  end

  // Double: exponent below 1025 always means a right shift of 28 or more.
  always_comb begin
    if (e64 >= 11'd1025) begin
      mag64 = MAG_SAT;
    end else begin
      mag64 = 26'({1'b1, f64} >> (11'd1052 - e64));
    end
  end

  always_comb begin
    q        = '0;
    clip     = 1'b0;
    neg      = 1'b0;
    mag      = '0;
    is_float = 1'b0;
    if (!silent) begin
      unique case (fmt)
        FMT_PCM16: q = {raw[15:0], 8'h00};
        FMT_PCM24: q = raw[23:0];
        FMT_PCM32: q = raw[31:8];
        FMT_FLOAT32: begin
          neg = raw[31];
          if (e32 == 8'hFF) begin
            clip = 1'b1;
            if (f32 == '0) q = neg ? Q_MIN : Q_MAX;
          end else if (e32 != '0) begin
            is_float = 1'b1;
            mag      = mag32;
          end
        end
        FMT_FLOAT64: begin
          neg = raw[63];
          if (e64 == 11'h7FF) begin
            clip = 1'b1;
            if (f64 == '0) q = neg ? Q_MIN : Q_MAX;
          end else if (e64 != '0) begin
            is_float = 1'b1;
            mag      = mag64;
          end
        end
        default: q = '0;
      endcase
      if (is_float) begin
        if (neg) begin
          if (mag > MAG_NEG_LIM) begin
            clip = 1'b1;
            q    = Q_MIN;
          end else begin
            q = SAMPLE_W'(~mag + 26'd1);
          end
        end else begin
          if (mag > MAG_POS_LIM) begin
            clip = 1'b1;
            q    = Q_MAX;
          end else begin
            q = mag[SAMPLE_W-1:0];
          end
        end
      end
    end
  end

endmodule
`default_nettype wire

// File: hdl/mmbd_div.sv
// Bit-serial signed divider, truncating toward zero, one quotient bit a cycle.
`default_nettype none
module mmbd_div
  import mmbd_pkg::*;
#(
  parameter int N_W = 28,
  parameter int D_W = 4
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic signed [N_W-1:0] dividend,
  input  logic [D_W-1:0]        divisor,
  output logic signed [N_W-1:0] quotient,
  output div_status_t           status
);

  localparam int CNT_W = $clog2(N_W + 1);

  logic [CNT_W-1:0] cnt;
  logic [D_W-1:0]   rem;
  logic [D_W-1:0]   dvs;
  logic [N_W-1:0]   quo;
  logic             neg;
  logic [D_W:0]     shifted;
  logic             fits;

  assign shifted = {rem, quo[N_W-1]};
  assign fits    = shifted >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      status <= '0;
      cnt    <= '0;
    end else begin
      status.done <= 1'b0;
      if (start) begin
        status.busy <= 1'b1;
        cnt         <= CNT_W'(N_W);
      end else if (status.busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          status.busy <= 1'b0;
          status.done <= 1'b1;
        end
      end
    end
  end

  // Divide the magnitude; restore the sign at the output.
  always_ff @(posedge clk) begin
    if (start) begin
      neg <= dividend[N_W-1];
      quo <= dividend[N_W-1] ? (~dividend + N_W'(1)) : dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (status.busy) begin
      quo <= {quo[N_W-2:0], fits};
      rem <= fits ? D_W'(shifted - {1'b0, dvs}) : shifted[D_W-1:0];
    end
  end

  assign quotient = neg ? $signed(~quo + N_W'(1)) : $signed(quo);

endmodule
`default_nettype wire

// File: hdl/mono_mix_boxcar_decimator_unit.sv
// Top level of the mono-mix boxcar decimator.
`default_nettype none
`include "mono_mix_boxcar_decimator_unit_defines.svh"
// Takes one interleaved capture sample per input item, decodes it to Q1.23
// (pcm16, pcm24, pcm32, float32, float64; other formats and silent items
// read as zero), averages each frame of channel_count samples to mono and
// each window of decimation_factor mono values to one output item, both
// with truncating division. tlast on an input item drops any partial frame
// and window after that item. Steps: an item that does not close a frame
// is accepted, then accumulated. Each division runs on one shared
// bit-serial divider that produces one quotient bit a cycle and is SUM_W
// bits wide; closing a frame adds the channel division, closing a window
// adds the window division and a load of the output register once it is
// free (SUM_W = 24 + clog2(MAX_CHANNELS) + clog2(MAX_FACTOR), 31 at the
// defaults, so a window stays exact even when the counts shrink under a
// partial frame). The input is ready only between items; a finished result
// waits in the output register while the next item is taken.
module mono_mix_boxcar_decimator_unit
  import mmbd_pkg::*;
#(
  parameter int MAX_CHANNELS = 8,
  parameter int MAX_FACTOR   = 12
) (
  input  logic                       clk,
  input  logic                       rst,
  // configuration write port
  input  logic                       cfg_we,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_W-1:0]           cfg_data,
  // input stream
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [RAW_W-1:0]           s_tdata,   // [63:0] raw_sample
  input  logic                       s_tuser,   // [0] silent
  input  logic                       s_tlast,   // last_of_packet
  // output stream
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic signed [SAMPLE_W-1:0] m_tdata,   // [23:0] mono_sample
  output logic                       m_tuser    // [0] saturated
);

  localparam int SUM_W = SAMPLE_W + $clog2(MAX_CHANNELS) + $clog2(MAX_FACTOR);
  localparam int CH_W  = $clog2(MAX_CHANNELS + 1);
  localparam int FA_W  = $clog2(MAX_FACTOR + 1);
  localparam int DV_W  = (CH_W > FA_W) ? CH_W : FA_W;

  // configuration registers
  logic [2:0]       sample_format;
  logic [CFG_W-1:0] channel_count;
  logic [CFG_W-1:0] decimation_factor;

  // sequencer and accumulators
  state_t                     state, state_next;
  logic signed [SUM_W-1:0]    ch_sum;
  logic [CH_W-1:0]            ch_pos;
  logic signed [SUM_W-1:0]    win_sum;
  logic [FA_W-1:0]            win_pos;
  logic                       clip_seen;

  // latched item
  logic signed [SAMPLE_W-1:0] q_reg;
  logic                       clip_reg;
  logic                       last_reg;

  logic signed [SAMPLE_W-1:0] dec_q;
  logic                       dec_clip;
  logic [CH_W-1:0]            chans;
  logic [FA_W-1:0]            factor;
  logic [CH_W-1:0]            ch_pos_inc;
  logic [FA_W-1:0]            win_pos_inc;
  logic signed [SUM_W-1:0]    ch_sum_add;
  logic signed [SUM_W-1:0]    win_sum_add;
  logic                       frame_done;
  logic                       window_done;
  logic                       out_free;

  logic                       div_start;
  logic signed [SUM_W-1:0]    div_dividend;
  logic [DV_W-1:0]            div_divisor;
  logic signed [SUM_W-1:0]    div_quo;
  div_status_t                div_status;

  mmbd_decode u_decode (
    .fmt    (sample_format),
    .raw    (s_tdata),
    .silent (s_tuser),
    .q      (dec_q),
    .clip   (dec_clip)
  );

  mmbd_div #(
    .N_W (SUM_W),
    .D_W (DV_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quotient (div_quo),
    .status   (div_status)
  );

  // Clamp counts: zero acts as one, anything above the cap acts as the cap.
  always_comb begin
    if (channel_count == '0) begin
      chans = CH_W'(1);
    end else if (int'(channel_count) > MAX_CHANNELS) begin
      chans = CH_W'(MAX_CHANNELS);
    end else begin
      chans = CH_W'(channel_count);
    end
    if (decimation_factor == '0) begin
      factor = FA_W'(1);
    end else if (int'(decimation_factor) > MAX_FACTOR) begin
      factor = FA_W'(MAX_FACTOR);
    end else begin
      factor = FA_W'(decimation_factor);
    end
  end

  assign ch_pos_inc  = ch_pos + CH_W'(1);
  assign win_pos_inc = win_pos + FA_W'(1);
  assign ch_sum_add  = ch_sum + SUM_W'(q_reg);
  assign win_sum_add = win_sum + div_quo;
  assign frame_done  = ch_pos_inc >= chans;
  assign window_done = win_pos_inc >= factor;
  assign out_free    = !m_tvalid || m_tready;
  assign s_tready    = (state == ST_IDLE);

  // Sequencer: accumulate, divide for mono, then on a closed window divide and push.
  always_comb begin
    state_next   = state;
    div_start    = 1'b0;
    div_dividend = ch_sum_add;
    div_divisor  = DV_W'(chans);
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) state_next = ST_ACCUM;
      end
      ST_ACCUM: begin
        if (frame_done) begin
          div_start  = 1'b1;
          state_next = ST_CHDIV;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_CHDIV: begin
        div_dividend = win_sum_add;
        div_divisor  = DV_W'(factor);
        if (div_status.done) begin
          if (window_done) begin
            div_start  = 1'b1;
            state_next = ST_WINDIV;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      ST_WINDIV: begin
        if (div_status.done) state_next = ST_PUSH;
      end
      ST_PUSH: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= ST_IDLE;
      sample_format     <= FMT_PCM16;
      channel_count     <= CFG_W'(1);
      decimation_factor <= CFG_W'(3);
      ch_sum            <= '0;
      ch_pos            <= '0;
      win_sum           <= '0;
      win_pos           <= '0;
      clip_seen         <= 1'b0;
      m_tvalid          <= 1'b0;
    end else begin
      state <= state_next;

      if (cfg_we) begin
        unique case (cfg_index)
          REG_SAMPLE_FORMAT:     sample_format     <= cfg_data[2:0];
          REG_CHANNEL_COUNT:     channel_count     <= cfg_data;
          REG_DECIMATION_FACTOR: decimation_factor <= cfg_data;
          default: ;
        endcase
      end

      // Load a new output item, or drop the one just taken.
      if (state == ST_PUSH && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end

      unique case (state)
        ST_ACCUM: begin
          if (frame_done) begin
            // sum goes to the divider this edge; start the next frame
            clip_seen <= clip_seen | clip_reg;
            ch_sum    <= '0;
            ch_pos    <= '0;
          end else if (last_reg) begin
            // drop the partial frame and window
            ch_sum    <= '0;
            ch_pos    <= '0;
            win_sum   <= '0;
            win_pos   <= '0;
            clip_seen <= 1'b0;
          end else begin
            clip_seen <= clip_seen | clip_reg;
            ch_sum    <= ch_sum_add;
            ch_pos    <= ch_pos_inc;
          end
        end
        ST_CHDIV: begin
          if (div_status.done) begin
            if (window_done || last_reg) begin
              win_sum <= '0;
              win_pos <= '0;
              if (!window_done) clip_seen <= 1'b0;
            end else begin
              win_sum <= win_sum_add;
              win_pos <= win_pos_inc;
            end
          end
        end
        ST_PUSH: begin
          if (out_free) clip_seen <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  // Payload registers: no reset needed.
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && s_tvalid) begin
      q_reg    <= dec_q;
      clip_reg <= dec_clip;
      last_reg <= s_tlast;
    end
    if (state == ST_PUSH && out_free) begin
      m_tdata <= div_quo[SAMPLE_W-1:0];
      m_tuser <= clip_seen;
    end
  end

  // Never take an item while the divider is working.
  `MMBD_ASSERT_IMPL(a_busy_not_ready, div_status.busy, !s_tready)
  // The divider only finishes while the sequencer waits for it.
  `MMBD_ASSERT_IMPL(a_done_when_waiting, div_status.done,
                    state == ST_CHDIV || state == ST_WINDIV)
  // Between items both positions stay below their caps.
  `MMBD_ASSERT_IMPL(a_pos_in_range, state == ST_IDLE,
                    ch_pos < MAX_CHANNELS && win_pos < MAX_FACTOR)
  // A free output register takes the window result and the block goes idle.
  `MMBD_ASSERT_NEXT(a_push_loads, state == ST_PUSH && out_free,
                    m_tvalid && state == ST_IDLE)

endmodule
`default_nettype wire
